FILE: hw/rtl/afk_pkg.sv
`timescale 1ns / 1ps

package afk_pkg;

    localparam int POS_W  = 24;
    localparam int ANG_W  = 16;
    localparam int LEN_W  = 16;
    localparam int SUM_W  = 18;
    localparam int TRIG_W = 33;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_STEPS   = 24;

    localparam int ANGLE_TURN = 23040;
    localparam int HALF_TURN  = 11520;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    localparam logic [LEN_W-1:0] BASE_HEIGHT_RESET = 16'd256;
    localparam logic [LEN_W-1:0] UPPER_ARM_RESET   = 16'd1280;
    localparam logic [LEN_W-1:0] LOWER_ARM_RESET   = 16'd1280;
    localparam logic [LEN_W-1:0] HAND_RESET        = 16'd256;

    localparam logic [29:0] ATAN_TABLE [MAX_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331, 30'd21354465, 30'd10680862, 30'd5340245,
        30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
        30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE_HEIGHT = 2'd0,
        CFG_UPPER_ARM   = 2'd1,
        CFG_LOWER_ARM   = 2'd2,
        CFG_HAND        = 2'd3
    } cfg_index_t;

    typedef logic signed [SUM_W-1:0]  angle_sum_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [POS_W-1:0]  pos_t;

endpackage

FILE: hw/rtl/afk_pose_if.sv
`timescale 1ns / 1ps

interface afk_pose_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] base_x;
    logic signed [23:0] base_y;
    logic signed [23:0] base_z;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] shoulder_elevation;
    logic signed [15:0] elbow_bend;
    logic signed [15:0] wrist_bend;

    modport source (output valid, base_x, base_y, base_z, yaw_angle,
                    shoulder_elevation, elbow_bend, wrist_bend, input ready);
    modport sink (input valid, base_x, base_y, base_z, yaw_angle,
                  shoulder_elevation, elbow_bend, wrist_bend, output ready);
endinterface

FILE: hw/rtl/afk_point_if.sv
`timescale 1ns / 1ps

interface afk_point_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] elbow_x;
    logic signed [23:0] elbow_y;
    logic signed [23:0] elbow_z;
    logic signed [23:0] wrist_x;
    logic signed [23:0] wrist_y;
    logic signed [23:0] wrist_z;
    logic signed [23:0] palm_x;
    logic signed [23:0] palm_y;
    logic signed [23:0] palm_z;

    modport source (output valid, elbow_x, elbow_y, elbow_z, wrist_x, wrist_y,
                    wrist_z, palm_x, palm_y, palm_z, input ready);
    modport sink (input valid, elbow_x, elbow_y, elbow_z, wrist_x, wrist_y,
                  wrist_z, palm_x, palm_y, palm_z, output ready);
endinterface

FILE: hw/rtl/afk_trig.sv
`timescale 1ns / 1ps

module afk_trig #(
    parameter int ITER = 16
) (
    input  logic               clk,
    input  logic               en,
    input  afk_pkg::angle_sum_t angle,
    output afk_pkg::trig_t     cos_q30,
    output afk_pkg::trig_t     sin_q30
);
    import afk_pkg::*;

    localparam int STEPS = (ITER > MAX_STEPS) ? MAX_STEPS : ITER;
    localparam logic [58:0] FRAC_RECIP = 59'd763549742;

    logic [14:0] r_reg, r_next;
    logic [8:0]  q_reg, q_next;
    logic [5:0]  m_reg, m_next;
    logic [31:0] t_reg, t_next;
    trig_t       x_reg [0:STEPS];
    trig_t       y_reg [0:STEPS];
    trig_t       z_reg [0:STEPS];
    logic        neg_reg [0:STEPS];
    trig_t       cos_reg, sin_reg;

    logic [17:0] wrap;
    logic [30:0] q_prod;
    logic [28:0] frac_num;
    logic [58:0] frac_prod;
    logic [31:0] folded;

    always_comb
    begin
        wrap = 18'($unsigned(angle) + 18'(5 * ANGLE_TURN));
        if (wrap >= 18'(8 * ANGLE_TURN)) wrap = wrap - 18'(8 * ANGLE_TURN);
        if (wrap >= 18'(4 * ANGLE_TURN)) wrap = wrap - 18'(4 * ANGLE_TURN);
        if (wrap >= 18'(2 * ANGLE_TURN)) wrap = wrap - 18'(2 * ANGLE_TURN);
        if (wrap >= 18'(ANGLE_TURN)) wrap = wrap - 18'(ANGLE_TURN);
        r_next = wrap[14:0];
    end

    // The remainder is split as 45 * q + m so the binary angle is q * 2^23 plus a
    // fraction below 2^23.
    assign q_prod    = 31'(r_reg) * 31'd46604;
    assign q_next    = q_prod[29:21];
    assign m_next    = 6'(r_reg - 15'(q_next) * 15'd45);
    assign frac_num  = {m_reg, 23'd0} + 29'd22;
    assign frac_prod = 59'(frac_num) * FRAC_RECIP;
    assign t_next    = {q_reg, frac_prod[57:35]};
    assign folded    = {t_reg[31] ^ (t_reg[31] ^ t_reg[30]), t_reg[30:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= r_next;
            q_reg      <= q_next;
            m_reg      <= m_next;
            t_reg      <= t_next;
            neg_reg[0] <= t_reg[31] ^ t_reg[30];
            x_reg[0]   <= TRIG_W'(CORDIC_GAIN_Q30);
            y_reg[0]   <= '0;
            z_reg[0]   <= TRIG_W'($signed(folded));
            cos_reg    <= neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
            sin_reg    <= neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][TRIG_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - TRIG_W'(ATAN_TABLE[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + TRIG_W'(ATAN_TABLE[i]);
                end
            end
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

FILE: hw/rtl/arm_forward_kinematics.sv
`timescale 1ns / 1ps
// Channel  Role    Carries
// pose     sink    base position and four joint angles, one request per pose
// points   source  elbow, wrist and palm positions, one request per pose
// cfg      write   base height and three link lengths, by register index
//
// A pose passes the CORDIC stages of the trig units, then the product and sum
// registers; one pose enters every cycle unless the pipeline holds.
// Reset clears the valid bits and restores the default lengths.
// When the result register is full and not taken, the whole pipeline holds.

module arm_forward_kinematics #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    afk_pose_if.sink                        pose,
    afk_point_if.source                     points,
    input  logic                            cfg_we,
    input  logic [afk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [afk_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import afk_pkg::*;

    localparam int STEPS    = (TRIG_ITERATIONS > MAX_STEPS) ? MAX_STEPS : TRIG_ITERATIONS;
    localparam int TRIG_LAT = STEPS + 5;
    localparam int LINE     = TRIG_LAT + 2;
    localparam int WIDE_W   = 27;

    function automatic logic signed [22:0] round_q30(input logic signed [52:0] p);
        logic signed [52:0] s;
        s = p + 53'sd536870912;
        return s[52:30];
    endfunction

    function automatic pos_t saturate(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_W'(8388607)) return 24'sh7FFFFF;
        if (v < -WIDE_W'(8388608)) return 24'sh800000;
        return v[POS_W-1:0];
    endfunction

    logic [LEN_W-1:0] base_height_reg, upper_reg, lower_reg, hand_reg;
    logic             en;
    logic             vld_reg [0:LINE-1];
    pos_t             bx_reg [0:LINE-1];
    pos_t             by_reg [0:LINE-1];
    pos_t             bz_reg [0:LINE-1];
    logic             out_vld_reg;

    angle_sum_t a_yaw, a_up, a_low, a_hand;
    trig_t      cy, sy, cu, su, cl, sl, ch, sh;

    trig_t              cy_reg, sy_reg;
    logic signed [19:0] hu_reg, hl_reg, hh_reg, uy_reg, ly_reg, hy_reg;
    logic signed [22:0] ux_reg, uz_reg, lx_reg, lz_reg, hx_reg, hz_reg;
    logic signed [19:0] uy2_reg, ly2_reg, hy2_reg;

    logic signed [WIDE_W-1:0] e_x, e_y, e_z, w_x, w_y, w_z, p_x, p_y, p_z;
    pos_t ex_reg, ey_reg, ez_reg, wx_reg, wy_reg, wz_reg, px_reg, py_reg, pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg <= BASE_HEIGHT_RESET;
            upper_reg       <= UPPER_ARM_RESET;
            lower_reg       <= LOWER_ARM_RESET;
            hand_reg        <= HAND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BASE_HEIGHT: base_height_reg <= cfg_data;
                CFG_UPPER_ARM:   upper_reg <= cfg_data;
                CFG_LOWER_ARM:   lower_reg <= cfg_data;
                CFG_HAND:        hand_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign en         = !out_vld_reg || points.ready;
    assign pose.ready = en;

    assign a_yaw  = SUM_W'(pose.yaw_angle);
    assign a_up   = SUM_W'(pose.shoulder_elevation);
    assign a_low  = SUM_W'(pose.shoulder_elevation) + SUM_W'(pose.elbow_bend)
                    - SUM_W'(HALF_TURN);
    assign a_hand = SUM_W'(pose.shoulder_elevation) + SUM_W'(pose.elbow_bend)
                    + SUM_W'(pose.wrist_bend);

    afk_trig #(.ITER(TRIG_ITERATIONS)) u_trig_yaw
        (.clk(clk), .en(en), .angle(a_yaw), .cos_q30(cy), .sin_q30(sy));
    afk_trig #(.ITER(TRIG_ITERATIONS)) u_trig_up
        (.clk(clk), .en(en), .angle(a_up), .cos_q30(cu), .sin_q30(su));
    afk_trig #(.ITER(TRIG_ITERATIONS)) u_trig_low
        (.clk(clk), .en(en), .angle(a_low), .cos_q30(cl), .sin_q30(sl));
    afk_trig #(.ITER(TRIG_ITERATIONS)) u_trig_hand
        (.clk(clk), .en(en), .angle(a_hand), .cos_q30(ch), .sin_q30(sh));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LINE; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= pose.valid;
            for (int k = 1; k < LINE; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_vld_reg <= vld_reg[LINE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bx_reg[0] <= pose.base_x;
            by_reg[0] <= pose.base_y;
            bz_reg[0] <= pose.base_z;
            for (int k = 1; k < LINE; k++)
            begin
                bx_reg[k] <= bx_reg[k-1];
                by_reg[k] <= by_reg[k-1];
                bz_reg[k] <= bz_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cy_reg <= cy;
            sy_reg <= sy;
            hu_reg <= 20'(round_q30(53'($signed({1'b0, upper_reg})) * 53'(cu)));
            uy_reg <= 20'(round_q30(53'($signed({1'b0, upper_reg})) * 53'(su)));
            hl_reg <= 20'(round_q30(53'($signed({1'b0, lower_reg})) * 53'(cl)));
            ly_reg <= 20'(round_q30(53'($signed({1'b0, lower_reg})) * 53'(sl)));
            hh_reg <= 20'(round_q30(53'($signed({1'b0, hand_reg})) * 53'(ch)));
            hy_reg <= 20'(round_q30(53'($signed({1'b0, hand_reg})) * 53'(sh)));

            ux_reg  <= round_q30(53'(hu_reg) * 53'(cy_reg));
            uz_reg  <= round_q30(53'(hu_reg) * 53'(sy_reg));
            lx_reg  <= round_q30(53'(hl_reg) * 53'(cy_reg));
            lz_reg  <= round_q30(53'(hl_reg) * 53'(sy_reg));
            hx_reg  <= round_q30(53'(hh_reg) * 53'(cy_reg));
            hz_reg  <= round_q30(53'(hh_reg) * 53'(sy_reg));
            uy2_reg <= uy_reg;
            ly2_reg <= ly_reg;
            hy2_reg <= hy_reg;

            ex_reg <= saturate(e_x);
            ey_reg <= saturate(e_y);
            ez_reg <= saturate(e_z);
            wx_reg <= saturate(w_x);
            wy_reg <= saturate(w_y);
            wz_reg <= saturate(w_z);
            px_reg <= saturate(p_x);
            py_reg <= saturate(p_y);
            pz_reg <= saturate(p_z);
        end
    end

    always_comb
    begin
        e_x = WIDE_W'(bx_reg[LINE-1]) + WIDE_W'(ux_reg);
        e_y = WIDE_W'(by_reg[LINE-1]) + WIDE_W'($signed({1'b0, base_height_reg}))
              + WIDE_W'(uy2_reg);
        e_z = WIDE_W'(bz_reg[LINE-1]) + WIDE_W'(uz_reg);
        w_x = e_x + WIDE_W'(lx_reg);
        w_y = e_y + WIDE_W'(ly2_reg);
        w_z = e_z + WIDE_W'(lz_reg);
        p_x = w_x + WIDE_W'(hx_reg);
        p_y = w_y + WIDE_W'(hy2_reg);
        p_z = w_z + WIDE_W'(hz_reg);
    end

    assign points.valid   = out_vld_reg;
    assign points.elbow_x = ex_reg;
    assign points.elbow_y = ey_reg;
    assign points.elbow_z = ez_reg;
    assign points.wrist_x = wx_reg;
    assign points.wrist_y = wy_reg;
    assign points.wrist_z = wz_reg;
    assign points.palm_x  = px_reg;
    assign points.palm_y  = py_reg;
    assign points.palm_z  = pz_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pose.valid && pose.ready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_tail_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LINE-1]) |=> out_vld_reg)
        else $error("pipeline tail request was dropped");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !points.ready) |=> (out_vld_reg && $stable(px_reg)
                                            && $stable(vld_reg[LINE-1])))
        else $error("pipeline moved while the result was stalled");

endmodule

FILE: tb/sv/arm_forward_kinematics_checker.sv
`timescale 1ns / 1ps

module arm_forward_kinematics_checker #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    afk_pose_if                             pose,
    afk_point_if                            points,
    input  logic                            cfg_we,
    input  logic [afk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [afk_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              pending
);
    import afk_pkg::*;

    typedef pos_t [0:8] point_set_t;

    localparam longint ATAN_VALUES [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    localparam longint POS_HIGH = 8388607;
    localparam longint POS_LOW  = -8388608;

    longint unsigned shoulder_height;
    longint unsigned upper_len;
    longint unsigned lower_len;
    longint unsigned hand_len;
    point_set_t      expected_points[$];

    function automatic longint round_q8_8(input longint p);
        return (p + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic pos_t clamp_pos(input longint v);
        if (v > POS_HIGH)
            return pos_t'(POS_HIGH);
        if (v < POS_LOW)
            return pos_t'(POS_LOW);
        return pos_t'(v);
    endfunction

    function automatic void angle_trig(input longint ang, output longint c, output longint s);
        longint          r;
        longint unsigned t;
        logic [31:0]     bam;
        bit              flip;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        int              steps;
        r = ang % ANGLE_TURN;
        if (r < 0)
            r += ANGLE_TURN;
        t = ((longint'(r) << 23) + 22) / 45;
        bam = t[31:0];
        flip = (bam[31:30] == 2'd1) || (bam[31:30] == 2'd2);
        if (flip)
            bam = bam - 32'h8000_0000;
        z = longint'(signed'(bam));
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        steps = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;
        for (int i = 0; i < steps; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= ATAN_VALUES[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += ATAN_VALUES[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void link_offset(input longint len, input longint elev,
                                        input longint cy, input longint sy,
                                        output longint dx, output longint dy,
                                        output longint dz);
        longint ce;
        longint se;
        longint h;
        angle_trig(elev, ce, se);
        h = round_q8_8(len * ce);
        dy = round_q8_8(len * se);
        dx = round_q8_8(h * cy);
        dz = round_q8_8(h * sy);
    endfunction

    function automatic point_set_t arm_points(input longint bx, input longint by,
                                              input longint bz, input longint yaw,
                                              input longint sh, input longint el,
                                              input longint wr);
        longint     cy;
        longint     sy;
        longint     d[9];
        longint     p[9];
        point_set_t res;
        angle_trig(yaw, cy, sy);
        link_offset(longint'(upper_len), sh, cy, sy, d[0], d[1], d[2]);
        link_offset(longint'(lower_len), sh + el - HALF_TURN, cy, sy, d[3], d[4], d[5]);
        link_offset(longint'(hand_len), sh + el + wr, cy, sy, d[6], d[7], d[8]);
        p[0] = bx + d[0];
        p[1] = by + longint'(shoulder_height) + d[1];
        p[2] = bz + d[2];
        for (int k = 3; k < 9; k++)
            p[k] = p[k-3] + d[k];
        for (int k = 0; k < 9; k++)
            res[k] = clamp_pos(p[k]);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_set_t got;
        point_set_t want;
        if (!rst_n)
        begin
            shoulder_height <= 64'(BASE_HEIGHT_RESET);
            upper_len       <= 64'(UPPER_ARM_RESET);
            lower_len       <= 64'(LOWER_ARM_RESET);
            hand_len        <= 64'(HAND_RESET);
        end
        else
        begin
            if (pose.valid && pose.ready)
                expected_points.push_back(arm_points(longint'(pose.base_x),
                                                     longint'(pose.base_y),
                                                     longint'(pose.base_z),
                                                     longint'(pose.yaw_angle),
                                                     longint'(pose.shoulder_elevation),
                                                     longint'(pose.elbow_bend),
                                                     longint'(pose.wrist_bend)));
            if (points.valid && points.ready)
            begin
                got = {points.elbow_x, points.elbow_y, points.elbow_z,
                       points.wrist_x, points.wrist_y, points.wrist_z,
                       points.palm_x, points.palm_y, points.palm_z};
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected point request %h", $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== want[k])
                        begin
                            $display("%0t: point field %0d expected %0d actual %0d",
                                     $time, k, want[k], got[k]);
                            errors = errors + 1;
                        end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_BASE_HEIGHT: shoulder_height <= 64'(cfg_data);
                    CFG_UPPER_ARM:   upper_len <= 64'(cfg_data);
                    CFG_LOWER_ARM:   lower_len <= 64'(cfg_data);
                    CFG_HAND:        hand_len <= 64'(cfg_data);
                    default: ;
                endcase
            end
        end
        pending = expected_points.size();
    end

    initial
    begin
        errors = 0;
        pending = 0;
    end

endmodule

FILE: tb/sv/arm_forward_kinematics_tb.sv
`timescale 1ns / 1ps

module arm_forward_kinematics_tb;
    import afk_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     errors;
    int                     pending;
    int                     cycles;
    bit                     sender_calm;
    bit                     receiver_calm;

    afk_pose_if  pose ();
    afk_point_if points ();

    arm_forward_kinematics u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .points    (points),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arm_forward_kinematics_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .points    (points),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("arm_forward_kinematics_tb: FAIL");
            $finish;
        end
    end

    function automatic int draw_wait(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    initial
    begin
        int w;
        points.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 59) == 0)
                receiver_calm = !receiver_calm;
            w = draw_wait(receiver_calm);
            if (w > 0)
            begin
                points.ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            points.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(points.valid && points.ready));
        end
    end

    task automatic send_pose(input logic [23:0] bx, input logic [23:0] by,
                             input logic [23:0] bz, input logic [15:0] yaw,
                             input logic [15:0] sh, input logic [15:0] el,
                             input logic [15:0] wr);
        int w;
        if ($urandom_range(0, 59) == 0)
            sender_calm = !sender_calm;
        w = draw_wait(sender_calm);
        if (w > 0)
        begin
            pose.valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        pose.valid              <= 1'b1;
        pose.base_x             <= bx;
        pose.base_y             <= by;
        pose.base_z             <= bz;
        pose.yaw_angle          <= yaw;
        pose.shoulder_elevation <= sh;
        pose.elbow_bend         <= el;
        pose.wrist_bend         <= wr;
        do
            @(posedge clk);
        while (!(pose.valid && pose.ready));
        @(negedge clk);
    endtask

    task automatic settle;
        pose.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_lengths(input logic [15:0] height, input logic [15:0] upper,
                                 input logic [15:0] lower, input logic [15:0] hand);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_HEIGHT;
        cfg_data  <= height;
        @(negedge clk);
        cfg_index <= CFG_UPPER_ARM;
        cfg_data  <= upper;
        @(negedge clk);
        cfg_index <= CFG_LOWER_ARM;
        cfg_data  <= lower;
        @(negedge clk);
        cfg_index <= CFG_HAND;
        cfg_data  <= hand;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [23:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 24'h7FFFFF - 24'($urandom_range(0, 70000));
            1: return 24'h800000 + 24'($urandom_range(0, 70000));
            2: return 24'(signed'(16'($urandom())));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 7) * 2880);
            default: return 16'($urandom_range(0, 46080) - 23040);
        endcase
    endfunction

    task automatic random_poses(input int count);
        repeat (count)
            send_pose(rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(),
                      rand_angle(), rand_angle());
    endtask

    initial
    begin
        cycles        = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_BASE_HEIGHT;
        cfg_data      = '0;
        pose.valid    = 1'b0;
        pose.base_x   = '0;
        pose.base_y   = '0;
        pose.base_z   = '0;
        pose.yaw_angle          = '0;
        pose.shoulder_elevation = '0;
        pose.elbow_bend         = '0;
        pose.wrist_bend         = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pose(24'h0, 24'h0, 24'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_pose(24'h0, 24'h0, 24'h0, 16'sd5760, 16'sd5760, 16'sd11520, 16'sd5760);
        send_pose(24'h0, 24'h0, 24'h0, 16'sd11520, -16'sd5760, 16'sd2880, -16'sd2880);
        send_pose(24'h0, 24'h0, 24'h0, 16'sd23040, -16'sd23040, 16'sd23040, -16'sd23040);
        send_pose(24'h0, 24'h0, 24'h0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_pose(24'h0, 24'h0, 24'h0, 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555);
        send_pose(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'sd0, 16'sd5760, 16'sd0, 16'sd0);
        send_pose(24'h800000, 24'h800000, 24'h800000, 16'sd11520, -16'sd5760, 16'sd0,
                  16'sd0);
        send_pose(24'h555555, 24'hAAAAAA, 24'h000001, 16'sd2880, 16'sd8640, 16'sd17280,
                  -16'sd11520);
        send_pose(24'hFFFFFF, 24'h000100, 24'h7FFF00, -16'sd17280, 16'sd1, -16'sd1,
                  16'sd14400);
        settle();

        write_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pose(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'sd2880, 16'sd5760, 16'sd11520,
                  16'sd0);
        send_pose(24'h800000, 24'h800000, 24'h800000, 16'sd14400, -16'sd5760, 16'sd11520,
                  16'sd0);
        send_pose(24'h7FFF00, 24'h000000, 24'h800100, 16'sd5760, 16'sd0, 16'sd0, 16'sd0);
        random_poses(90);
        settle();

        write_lengths(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pose(24'h123456, 24'hFEDCBA, 24'h7FFFFF, 16'sd1000, 16'sd2000, 16'sd3000,
                  16'sd4000);
        random_poses(80);
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_lengths(16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
            random_poses(90);
            settle();
        end

        write_lengths(BASE_HEIGHT_RESET, UPPER_ARM_RESET, LOWER_ARM_RESET, HAND_RESET);
        random_poses(100);
        settle();

        if (errors == 0)
            $display("arm_forward_kinematics_tb: PASS");
        else
            $display("arm_forward_kinematics_tb: FAIL");
        $finish;
    end

endmodule

FILE: arm_forward_kinematics.f
hw/rtl/afk_pkg.sv
hw/rtl/afk_pose_if.sv
hw/rtl/afk_point_if.sv
hw/rtl/afk_trig.sv
hw/rtl/arm_forward_kinematics.sv
tb/sv/arm_forward_kinematics_checker.sv
tb/sv/arm_forward_kinematics_tb.sv
